// File: src/jdd_pkg.sv
// jdd_pkg: shared types and constants of the joystick direction and deflection block
// sequencer states, direction codes, register indexes and reset values
// no dependencies
`default_nettype none

package jdd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_LOAD,
      ST_ITER,
      ST_FINISH,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      DIR_NEUTRAL = 3'd0,
      DIR_UP      = 3'd1,
      DIR_DOWN    = 3'd2,
      DIR_LEFT    = 3'd3,
      DIR_RIGHT   = 3'd4
   } dir_type;

   typedef enum logic [1:0] {
      REG_DEADZONE = 2'd0,
      REG_HIGH_END = 2'd1,
      REG_LOW_END  = 2'd2,
      REG_NONE     = 2'd3
   } reg_index_type;

   localparam logic       OP_CLASSIFY = 1'b0;
   localparam logic       OP_CALIBRATE = 1'b1;

   localparam logic [7:0] DEADZONE_RESET = 8'd15;
   localparam logic [7:0] HIGH_END_RESET = 8'd255;
   localparam logic [7:0] LOW_END_RESET  = 8'd3;

   localparam logic [6:0] PCT_MAX  = 7'd100;
   localparam int         PCT_BITS = 7;
   localparam logic [2:0] LAST_BIT = 3'd6;

endpackage

`default_nettype wire

// File: src/joystick_direction_and_deflection_top.sv
// joystick_direction_and_deflection_top: classifies joystick samples and scales deflection
// one shared restoring compare/subtract unit runs both percentage divisions
// depends on jdd_pkg
//
//  channel  | handshake          | word
//  ---------+--------------------+----------------------------------------
//  req_     | req_valid/req_stall| opcode, x_sample, y_sample
//  rsp_     | rsp_valid/rsp_stall| direction, x_percent, y_percent
//  csr_     | csr_valid/csr_ready| csr_index, csr_data (always ready)
//
// a classify word with deflection runs a classify step, then two divisions of one setup,
// seven quotient bits and one finish step each, then an output step; calibrate and
// neutral words skip the divisions and go from classify straight to output
// synchronous reset restores centre to midscale and the registers to defaults
// req_stall is high from accept until the word enters the result register,
// which holds its word while rsp_stall is high
`default_nettype none

module joystick_direction_and_deflection_top #(
   parameter int SAMPLE_BITS = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_opcode,
   input  wire logic [7:0] req_x_sample,
   input  wire logic [7:0] req_y_sample,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_direction,
   output logic [6:0]      rsp_x_percent,
   output logic [6:0]      rsp_y_percent,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);
   import jdd_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int DW = SAMPLE_BITS + PCT_BITS;
   localparam logic [SB-1:0] MIDSCALE = SB'(1) << (SB - 1);

   state_type state_ff, state_in;

   logic          op_ff;
   logic [SB-1:0] xs_ff, ys_ff;
   logic [SB-1:0] cx_ff, cy_ff;
   logic [7:0]    dz_ff, hi_ff, lo_ff;
   logic [2:0]    dir_ff;
   logic          dom_x_ff;
   logic [SB-1:0] num0_ff, den0_ff, num1_ff, den1_ff;
   logic          sel_ff;
   logic [DW-1:0] rem_ff;
   logic [SB-1:0] den_ff;
   logic [6:0]    quo_ff;
   logic [2:0]    cnt_ff;
   logic          sat_ff;
   logic [6:0]    xp_ff, yp_ff;
   logic          rsp_valid_ff;
   logic [2:0]    rsp_dir_ff;
   logic [6:0]    rsp_xp_ff, rsp_yp_ff;

   logic          accept;
   logic          out_free;
   logic [SB-1:0] dx, dy, dz_w, hi_w, lo_w;
   logic [SB-1:0] div_hi_x, div_lo_x, div_hi_y, div_lo_y;
   logic          neutral;
   logic [SB-1:0] num_sel, den_sel;
   logic [DW-1:0] num_w, prod;
   logic [DW-1:0] trial_den;
   logic [DW:0]   trial;
   logic [6:0]    pct;

   function automatic logic [SB-1:0] absdiff(input logic [SB-1:0] a, input logic [SB-1:0] b);
      absdiff = (a > b) ? a - b : b - a;
   endfunction

   // classification datapath
   always_comb begin
      dz_w     = SB'(dz_ff);
      hi_w     = SB'(hi_ff);
      lo_w     = SB'(lo_ff);
      dx       = absdiff(xs_ff, cx_ff);
      dy       = absdiff(ys_ff, cy_ff);
      neutral  = (dx < dz_w) && (dy < dz_w);
      div_hi_x = absdiff(hi_w, cx_ff);
      div_lo_x = absdiff(lo_w, cx_ff);
      div_hi_y = absdiff(hi_w, cy_ff);
      div_lo_y = absdiff(lo_w, cy_ff);
   end

   // shared divider unit
   always_comb begin
      num_sel   = sel_ff ? num1_ff : num0_ff;
      den_sel   = sel_ff ? den1_ff : den0_ff;
      num_w     = DW'(num_sel);
      prod      = (num_w << 6) + (num_w << 5) + (num_w << 2);
      trial_den = DW'(den_ff) << cnt_ff;
      trial     = {1'b0, rem_ff} - {1'b0, trial_den};
      if (den_ff == '0) begin
         pct = '0;
      end else if (sat_ff || (quo_ff > PCT_MAX)) begin
         pct = PCT_MAX;
      end else begin
         pct = quo_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            if (op_ff == OP_CALIBRATE || neutral) state_in = ST_DONE;
            else state_in = ST_LOAD;
         end
         ST_LOAD: state_in = ST_ITER;
         ST_ITER: begin
            if (cnt_ff == '0) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sel_ff) state_in = ST_DONE;
            else state_in = ST_LOAD;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      req_stall = (state_ff != ST_IDLE);
      accept    = req_valid && !req_stall;
      csr_ready = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cx_ff        <= MIDSCALE;
         cy_ff        <= MIDSCALE;
         dz_ff        <= DEADZONE_RESET;
         hi_ff        <= HIGH_END_RESET;
         lo_ff        <= LOW_END_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (reg_index_type'(csr_index))
               REG_DEADZONE: dz_ff <= csr_data;
               REG_HIGH_END: hi_ff <= csr_data;
               REG_LOW_END:  lo_ff <= csr_data;
               REG_NONE: ;
               default: ;
            endcase
         end
         if (state_ff == ST_CLASSIFY && op_ff == OP_CALIBRATE) begin
            cx_ff <= xs_ff;
            cy_ff <= ys_ff;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_opcode;
         xs_ff <= SB'(req_x_sample);
         ys_ff <= SB'(req_y_sample);
      end
      unique case (state_ff)
         ST_CLASSIFY: begin
            sel_ff <= 1'b0;
            xp_ff  <= '0;
            yp_ff  <= '0;
            if (op_ff == OP_CALIBRATE || neutral) begin
               dir_ff <= DIR_NEUTRAL;
            end else if (dx > dy) begin
               dom_x_ff <= 1'b1;
               dir_ff   <= (xs_ff > cx_ff) ? DIR_RIGHT : DIR_LEFT;
               num0_ff  <= dx;
               den0_ff  <= (xs_ff > cx_ff) ? div_hi_x : div_lo_x;
               num1_ff  <= dy;
               den1_ff  <= cy_ff;
            end else begin
               dom_x_ff <= 1'b0;
               dir_ff   <= (ys_ff > cy_ff) ? DIR_UP : DIR_DOWN;
               num0_ff  <= dy;
               den0_ff  <= (ys_ff > cy_ff) ? div_hi_y : div_lo_y;
               num1_ff  <= dx;
               den1_ff  <= cx_ff;
            end
         end
         ST_LOAD: begin
            rem_ff <= prod;
            den_ff <= den_sel;
            quo_ff <= '0;
            cnt_ff <= LAST_BIT;
            sat_ff <= (prod[DW-1:PCT_BITS] >= den_sel);
         end
         ST_ITER: begin
            if (!trial[DW]) begin
               rem_ff         <= trial[DW-1:0];
               quo_ff[cnt_ff] <= 1'b1;
            end
            cnt_ff <= cnt_ff - 3'd1;
         end
         ST_FINISH: begin
            sel_ff <= 1'b1;
            if (dom_x_ff == sel_ff) yp_ff <= pct;
            else xp_ff <= pct;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_dir_ff <= dir_ff;
               rsp_xp_ff  <= xp_ff;
               rsp_yp_ff  <= yp_ff;
            end
         end
         ST_IDLE: ;
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_direction = rsp_dir_ff;
   assign rsp_x_percent = rsp_xp_ff;
   assign rsp_y_percent = rsp_yp_ff;

   a_neutral_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_direction == DIR_NEUTRAL) |-> (rsp_x_percent == '0 && rsp_y_percent == '0))
      else $error("neutral word with nonzero deflection");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_x_percent <= PCT_MAX && rsp_y_percent <= PCT_MAX))
      else $error("deflection above full scale");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CLASSIFY))
      else $error("accepted word did not start classification");

   a_iter_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER && cnt_ff == '0) |=> (state_ff == ST_FINISH))
      else $error("division did not finish after last quotient bit");

endmodule

`default_nettype wire
